// File: src/mtp_pkg.sv
// Shared types, codes and default sizes for the model tree prediction block.
// Depends on nothing; mtp_front, mtp_back and the top take names from here by scope.
`default_nettype none
package mtp_pkg;

	localparam int NODES_DEF     = 256;
	localparam int MAX_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [1:0] FEAT_DEGREE = 2'd0;
	localparam logic [1:0] FEAT_DATA   = 2'd1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_DEPTH   = 2'd2;
	localparam logic [1:0] ST_SAT     = 2'd3;

	// One input beat as it sits in the queue.
	typedef struct packed {
		logic               mode;
		logic [7:0]         node_index;
		logic               node_is_internal;
		logic [1:0]         feature_sel;
		logic signed [31:0] split_value;
		logic [8:0]         left_child;
		logic [8:0]         right_child;
		logic signed [31:0] coef_const;
		logic signed [31:0] coef_degree;
		logic signed [31:0] coef_data;
		logic signed [31:0] x_degree;
		logic signed [31:0] x_data;
	} item_t;

	// One word of the node store; the valid mark lives in the word itself.
	typedef struct packed {
		logic               valid;
		logic               internal;
		logic [1:0]         feature;
		logic signed [31:0] split;
		logic [8:0]         left;
		logic [8:0]         right;
		logic signed [31:0] c0;
		logic signed [31:0] c1;
		logic signed [31:0] c2;
	} node_t;

	// Queue head towards the back end.
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	// Back end control towards the front end.
	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

endpackage
`default_nettype wire

// File: src/mtp_if.sv
// Valid/ready channel interfaces for the load/query input and the result output.
// Depends on nothing.
`default_nettype none
interface mtp_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [7:0]         node_index;
	logic               node_is_internal;
	logic [1:0]         feature_sel;
	logic signed [31:0] split_value;
	logic [8:0]         left_child;
	logic [8:0]         right_child;
	logic signed [31:0] coef_const;
	logic signed [31:0] coef_degree;
	logic signed [31:0] coef_data;
	logic signed [31:0] x_degree;
	logic signed [31:0] x_data;

	modport source (
		output valid, mode, node_index, node_is_internal, feature_sel, split_value,
		output left_child, right_child, coef_const, coef_degree, coef_data,
		output x_degree, x_data,
		input  ready
	);
	modport sink (
		input  valid, mode, node_index, node_is_internal, feature_sel, split_value,
		input  left_child, right_child, coef_const, coef_degree, coef_data,
		input  x_degree, x_data,
		output ready
	);
endinterface

interface mtp_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] prediction;
	logic [1:0]         status;
	logic [7:0]         leaf_node;

	modport source (output valid, prediction, status, leaf_node, input ready);
	modport sink (input valid, prediction, status, leaf_node, output ready);
endinterface
`default_nettype wire

// File: src/mtp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module mtp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: src/mtp_front.sv
// Front end: accepts load/query beats and holds them in a short queue.
// Depends on mtp_pkg and mtp_if.
`default_nettype none
module mtp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	mtp_in_if.sink              load_query,
	input  mtp_pkg::back_ctl_t  ctl,
	output mtp_pkg::queue_head_t head
);

	localparam int PTR_W = (mtp_pkg::QUEUE_DEPTH > 1) ? $clog2(mtp_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(mtp_pkg::QUEUE_DEPTH + 1);

	mtp_pkg::item_t   slot_q [mtp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;
	mtp_pkg::item_t   item_in;

	always_comb begin
		item_in.mode             = load_query.mode;
		item_in.node_index       = load_query.node_index;
		item_in.node_is_internal = load_query.node_is_internal;
		item_in.feature_sel      = load_query.feature_sel;
		item_in.split_value      = load_query.split_value;
		item_in.left_child       = load_query.left_child;
		item_in.right_child      = load_query.right_child;
		item_in.coef_const       = load_query.coef_const;
		item_in.coef_degree      = load_query.coef_degree;
		item_in.coef_data        = load_query.coef_data;
		item_in.x_degree         = load_query.x_degree;
		item_in.x_data           = load_query.x_data;
	end

	// No beat is taken while the back end sweeps the node store after reset.
	assign load_query.ready = (count_q != CNT_W'(mtp_pkg::QUEUE_DEPTH)) && !ctl.clearing;
	assign push             = load_query.valid && load_query.ready;
	assign pop              = ctl.pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(mtp_pkg::QUEUE_DEPTH - 1)) ? '0
				            : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(mtp_pkg::QUEUE_DEPTH - 1)) ? '0
				            : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: src/mtp_back.sv
// Back end: writes loads into the node store, walks the tree for queries and
// evaluates the linear leaf through one shared multiplier.
// Depends on mtp_pkg, mtp_if and mtp_ram.
`default_nettype none
module mtp_back #(
	parameter int NODES     = mtp_pkg::NODES_DEF,
	parameter int MAX_DEPTH = mtp_pkg::MAX_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  mtp_pkg::queue_head_t head,
	output mtp_pkg::back_ctl_t   ctl,
	mtp_out_if.source            result
);

	localparam int IDX_W = $clog2(NODES);
	localparam int LVL_W = $clog2(MAX_DEPTH + 1);
	localparam int NODE_W = $bits(mtp_pkg::node_t);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_WALK, S_MUL1, S_MUL2, S_SUM, S_EMIT
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   clr_cnt_q;
	logic [IDX_W-1:0]   cur_q;
	logic [LVL_W-1:0]   level_q;
	logic signed [31:0] xd_q;
	logic signed [31:0] xa_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] pred_q;
	logic [1:0]         status_q;
	logic [7:0]         leaf_q;
	logic               out_valid_q;
	logic signed [63:0] out_pred_q;
	logic [1:0]         out_status_q;
	logic [7:0]         out_leaf_q;

	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	mtp_pkg::node_t      wr_node;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic [NODE_W-1:0]   rd_data;
	mtp_pkg::node_t      node;
	logic                is_query;
	logic                load_in_range;
	logic                go_left;
	logic [8:0]          link;
	logic                link_ok;
	logic [IDX_W-1:0]    next_idx;
	logic                at_depth;
	logic                descend;
	logic signed [31:0]  mul_a;
	logic signed [31:0]  mul_b;
	logic signed [63:0]  mul_p;
	logic signed [64:0]  sum;
	logic                slot_free;

	assign node          = mtp_pkg::node_t'(rd_data);
	assign is_query      = (head.item.mode == mtp_pkg::MODE_QUERY);
	assign load_in_range = (32'(head.item.node_index) < 32'(NODES));

	assign go_left = ((node.feature == mtp_pkg::FEAT_DEGREE) && (xd_q > node.split)) ||
	                 ((node.feature == mtp_pkg::FEAT_DATA) && (xa_q > node.split));
	assign link     = go_left ? node.left : node.right;
	assign link_ok  = (link != 9'd0) && (32'(link) <= 32'(NODES));
	assign next_idx = IDX_W'(32'(link) - 32'd1);
	assign at_depth = (level_q == LVL_W'(MAX_DEPTH));
	assign descend  = node.valid && node.internal && !at_depth && link_ok;

	always_comb begin
		wr_node          = '0;
		wr_node.valid    = 1'b1;
		wr_node.internal = head.item.node_is_internal;
		wr_node.feature  = head.item.feature_sel;
		wr_node.split    = head.item.split_value;
		wr_node.left     = head.item.left_child;
		wr_node.right    = head.item.right_child;
		wr_node.c0       = head.item.coef_const;
		wr_node.c1       = head.item.coef_degree;
		wr_node.c2       = head.item.coef_data;
		if (state_q == S_CLEAR) begin
			wr_node = '0;
		end
	end

	assign wr_en   = (state_q == S_CLEAR) ||
	                 ((state_q == S_IDLE) && head.valid && !is_query && load_in_range);
	assign wr_addr = (state_q == S_CLEAR) ? clr_cnt_q : IDX_W'(head.item.node_index);
	assign rd_en   = ((state_q == S_IDLE) && head.valid && is_query) ||
	                 ((state_q == S_WALK) && descend);
	assign rd_addr = (state_q == S_IDLE) ? '0 : next_idx;

	assign ctl.pop      = (state_q == S_IDLE) && head.valid;
	assign ctl.clearing = (state_q == S_CLEAR);

	mtp_ram #(
		.WIDTH (NODE_W),
		.DEPTH (NODES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_node),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// The leaf coefficients stay on the read port while the arithmetic runs.
	assign mul_a = (state_q == S_MUL1) ? node.c1 : node.c2;
	assign mul_b = (state_q == S_MUL1) ? xd_q : xa_q;
	assign mul_p = mul_a * mul_b;
	assign sum   = {acc_q[63], acc_q} + {prod_q[63], prod_q};

	assign slot_free = !out_valid_q || result.ready;

	assign result.valid      = out_valid_q;
	assign result.prediction = out_pred_q;
	assign result.status     = out_status_q;
	assign result.leaf_node  = out_leaf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A result taken while the next one is being emitted is replaced below.
			if (out_valid_q && result.ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + IDX_W'(1);
					if (clr_cnt_q == IDX_W'(NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (head.valid && is_query) begin
						xd_q    <= head.item.x_degree;
						xa_q    <= head.item.x_data;
						cur_q   <= '0;
						level_q <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (!node.valid) begin
						pred_q   <= '0;
						status_q <= mtp_pkg::ST_MISSING;
						leaf_q   <= '0;
						state_q  <= S_EMIT;
					end else if (!node.internal) begin
						leaf_q  <= 8'(cur_q);
						state_q <= S_MUL1;
					end else if (at_depth) begin
						pred_q   <= '0;
						status_q <= mtp_pkg::ST_DEPTH;
						leaf_q   <= '0;
						state_q  <= S_EMIT;
					end else if (!link_ok) begin
						pred_q   <= '0;
						status_q <= mtp_pkg::ST_MISSING;
						leaf_q   <= '0;
						state_q  <= S_EMIT;
					end else begin
						cur_q   <= next_idx;
						level_q <= level_q + LVL_W'(1);
					end
				end
				S_MUL1: begin
					prod_q  <= mul_p;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					// A 32 by 32 product plus a 32-bit term cannot leave 64 bits.
					acc_q   <= prod_q + {{32{node.c0[31]}}, node.c0};
					prod_q  <= mul_p;
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (sum[64] != sum[63]) begin
						pred_q   <= sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
						status_q <= mtp_pkg::ST_SAT;
					end else begin
						pred_q   <= sum[63:0];
						status_q <= mtp_pkg::ST_OK;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_pred_q   <= pred_q;
						out_status_q <= status_q;
						out_leaf_q   <= leaf_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: src/model_tree_predict_top.sv
// Model tree prediction: a load beat is written from the back end's idle state, which
// stays idle for the next beat; a query reads the node store once per level over 1 to
// MAX_DEPTH + 1 nodes, a leaf then passes S_MUL1, S_MUL2 and S_SUM on a shared multiplier,
// an error goes straight on, and both wait in S_EMIT until the output register is free.
// A query result waits in an output register while the next beat is taken.
// After reset the back end clears every word of the node store in turn, with ready low.
`default_nettype none
module model_tree_predict_top #(
	parameter int NODES     = mtp_pkg::NODES_DEF,
	parameter int MAX_DEPTH = mtp_pkg::MAX_DEPTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	mtp_in_if.sink    load_query,
	mtp_out_if.source result
);

	mtp_pkg::queue_head_t head;
	mtp_pkg::back_ctl_t   ctl;

	mtp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_query (load_query),
		.ctl        (ctl),
		.head       (head)
	);

	mtp_back #(
		.NODES     (NODES),
		.MAX_DEPTH (MAX_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.ctl    (ctl),
		.result (result)
	);

endmodule
`default_nettype wire
